@@ rtl/kms_pkg.sv @@
`timescale 1ns / 1ps
package kms_pkg;

   localparam int LANE_W = 3;
   localparam int KEY_W  = 64;
   localparam int VAL_W  = 64;
   localparam int CFG_W  = 4;

   localparam logic [CFG_W-1:0] LANES_USED_RESET = 4'd8;

   // one queued item, classified by the front end
   typedef struct packed {
      logic [LANE_W-1:0] lane;
      logic [KEY_W-1:0]  key;
      logic [VAL_W-1:0]  value;
      logic              stream_end;
      logic              in_use;
   } item_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EVAL,
      ST_SCAN,
      ST_EMIT,
      ST_DONE
   } state_type;

endpackage

@@ rtl/kms_front.sv @@
`timescale 1ns / 1ps
module kms_front #(
   parameter int LANES = 8,
   parameter int CW    = $clog2(LANES + 1)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [CW-1:0]                 n_act,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [kms_pkg::LANE_W-1:0]    req_lane,
   input  logic signed [kms_pkg::KEY_W-1:0] req_entry_key,
   input  logic [kms_pkg::VAL_W-1:0]     req_entry_value,
   input  logic                          req_stream_end,
   output logic                          q_valid,
   output kms_pkg::item_type             q_item,
   input  logic                          q_pop
);

   localparam int CMPW = (CW > kms_pkg::LANE_W) ? CW : kms_pkg::LANE_W;

   kms_pkg::item_type q_ff [2];
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic [1:0]        count_ff, count_in;
   logic              push;
   kms_pkg::item_type new_item;

   assign req_stall = (count_ff == 2'd2);
   assign push      = req_valid && !req_stall;
   assign q_valid   = (count_ff != 2'd0);
   assign q_item    = q_ff[rd_ptr_ff];

   always_comb begin
      new_item.lane       = req_lane;
      new_item.key        = req_entry_key;
      new_item.value      = req_entry_value;
      new_item.stream_end = req_stream_end;
      // lanes at or above the active count are treated as closed
      new_item.in_use     = (CMPW'(req_lane) < CMPW'(n_act));
   end

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = q_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !q_pop) begin
         count_in = count_ff + 2'd1;
      end else if (!push && q_pop) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule

@@ rtl/kms_back.sv @@
`timescale 1ns / 1ps
module kms_back #(
   parameter int LANES = 8,
   parameter int CW    = $clog2(LANES + 1),
   parameter int IW    = $clog2(LANES)
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic [CW-1:0]                    n_act,
   input  logic                             q_valid,
   input  kms_pkg::item_type                q_item,
   output logic                             q_pop,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [kms_pkg::VAL_W-1:0]        rsp_out_value,
   output logic signed [kms_pkg::KEY_W-1:0] rsp_out_key,
   output logic [kms_pkg::LANE_W-1:0]       rsp_source_lane,
   output logic                             rsp_done_res
);

   localparam int KW = kms_pkg::KEY_W;
   localparam int VW = kms_pkg::VAL_W;

   // head store: key in the upper half, value in the lower
   logic [KW+VW-1:0] head_mem [LANES];
   logic [KW+VW-1:0] rd_data_ff;

   kms_pkg::state_type state_ff, state_in;
   logic [LANES-1:0]   full_ff, full_in;
   logic [LANES-1:0]   closed_ff, closed_in;
   logic [LANES-1:0]   in_use_mask;
   logic [CW-1:0]      issue_idx_ff, issue_idx_in;
   logic               cmp_valid_ff, cmp_valid_in;
   logic [IW-1:0]      cmp_idx_ff, cmp_idx_in;
   logic               best_valid_ff, best_valid_in;
   logic [KW-1:0]      best_key_ff, best_key_in;
   logic [VW-1:0]      best_val_ff, best_val_in;
   logic [IW-1:0]      best_idx_ff, best_idx_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [VW-1:0]      rsp_value_ff, rsp_value_in;
   logic [KW-1:0]      rsp_key_ff, rsp_key_in;
   logic [kms_pkg::LANE_W-1:0] rsp_lane_ff, rsp_lane_in;
   logic               rsp_done_ff, rsp_done_in;
   logic               rsp_load;
   logic               out_free;
   logic               mem_we;
   logic [IW-1:0]      item_idx;
   logic               rd_en;
   logic [CW-1:0]      n_last;
   logic               any_open;
   logic               all_full;
   logic [KW-1:0]      rd_key;
   logic [VW-1:0]      rd_val;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign item_idx = IW'(q_item.lane);
   assign n_last   = CW'(n_act - 1'b1);
   assign rd_key   = rd_data_ff[KW+VW-1:VW];
   assign rd_val   = rd_data_ff[VW-1:0];

   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         in_use_mask[i] = (i < int'(n_act));
      end
   end

   assign any_open = |(in_use_mask & ~closed_ff);
   assign all_full = &(~in_use_mask | closed_ff | full_ff);

   always_comb begin
      state_in      = state_ff;
      full_in       = full_ff;
      closed_in     = closed_ff;
      issue_idx_in  = issue_idx_ff;
      cmp_valid_in  = 1'b0;
      cmp_idx_in    = cmp_idx_ff;
      best_valid_in = best_valid_ff;
      best_key_in   = best_key_ff;
      best_val_in   = best_val_ff;
      best_idx_in   = best_idx_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_load      = 1'b0;
      rsp_value_in  = rsp_value_ff;
      rsp_key_in    = rsp_key_ff;
      rsp_lane_in   = rsp_lane_ff;
      rsp_done_in   = rsp_done_ff;
      q_pop         = 1'b0;
      mem_we        = 1'b0;
      rd_en         = 1'b0;

      case (state_ff)
         kms_pkg::ST_IDLE: begin
            if (q_valid) begin
               q_pop    = 1'b1;
               state_in = kms_pkg::ST_EVAL;
               if (q_item.in_use && !closed_ff[item_idx]) begin
                  if (q_item.stream_end) begin
                     closed_in[item_idx] = 1'b1;
                     full_in[item_idx]   = 1'b0;
                  end else if (!full_ff[item_idx]) begin
                     full_in[item_idx] = 1'b1;
                     mem_we            = 1'b1;
                  end
               end
            end
         end
         kms_pkg::ST_EVAL: begin
            issue_idx_in  = '0;
            best_valid_in = 1'b0;
            if (!any_open) begin
               state_in = kms_pkg::ST_DONE;
            end else if (!all_full) begin
               state_in = kms_pkg::ST_IDLE;
            end else begin
               state_in = kms_pkg::ST_SCAN;
            end
         end
         kms_pkg::ST_SCAN: begin
            // issue one head read per cycle, compare it in the next cycle
            if (issue_idx_ff < n_act) begin
               rd_en        = 1'b1;
               cmp_valid_in = 1'b1;
               cmp_idx_in   = issue_idx_ff[IW-1:0];
               issue_idx_in = CW'(issue_idx_ff + 1'b1);
            end
            if (cmp_valid_ff) begin
               if (full_ff[cmp_idx_ff] &&
                   (!best_valid_ff || $signed(rd_key) < $signed(best_key_ff))) begin
                  best_valid_in = 1'b1;
                  best_key_in   = rd_key;
                  best_val_in   = rd_val;
                  best_idx_in   = cmp_idx_ff;
               end
               if (CW'(cmp_idx_ff) == n_last) begin
                  state_in = kms_pkg::ST_EMIT;
               end
            end
         end
         kms_pkg::ST_EMIT: begin
            if (out_free) begin
               rsp_load              = 1'b1;
               rsp_valid_in          = 1'b1;
               rsp_value_in          = best_val_ff;
               rsp_key_in            = best_key_ff;
               rsp_lane_in           = kms_pkg::LANE_W'(best_idx_ff);
               rsp_done_in           = 1'b0;
               full_in[best_idx_ff]  = 1'b0;
               state_in              = kms_pkg::ST_IDLE;
            end
         end
         kms_pkg::ST_DONE: begin
            if (out_free) begin
               rsp_load     = 1'b1;
               rsp_valid_in = 1'b1;
               rsp_value_in = '0;
               rsp_key_in   = '0;
               rsp_lane_in  = '0;
               rsp_done_in  = 1'b1;
               full_in      = '0;
               closed_in    = '0;
               state_in     = kms_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = kms_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= kms_pkg::ST_IDLE;
         full_ff       <= '0;
         closed_ff     <= '0;
         cmp_valid_ff  <= 1'b0;
         best_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         full_ff       <= full_in;
         closed_ff     <= closed_in;
         cmp_valid_ff  <= cmp_valid_in;
         best_valid_ff <= best_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      issue_idx_ff <= issue_idx_in;
      cmp_idx_ff   <= cmp_idx_in;
      best_key_ff  <= best_key_in;
      best_val_ff  <= best_val_in;
      best_idx_ff  <= best_idx_in;
      if (rsp_load) begin
         rsp_value_ff <= rsp_value_in;
         rsp_key_ff   <= rsp_key_in;
         rsp_lane_ff  <= rsp_lane_in;
         rsp_done_ff  <= rsp_done_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         head_mem[item_idx] <= {q_item.key, q_item.value};
      end
      if (rd_en) begin
         rd_data_ff <= head_mem[issue_idx_ff[IW-1:0]];
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_value   = rsp_value_ff;
   assign rsp_out_key     = rsp_key_ff;
   assign rsp_source_lane = rsp_lane_ff;
   assign rsp_done_res    = rsp_done_ff;

`ifndef NO_ASSERTIONS
   a_full_not_closed: assert property (@(posedge clock) disable iff (reset)
      (full_ff & closed_ff) == '0)
      else $error("lane both full and closed");

   a_emit_has_best: assert property (@(posedge clock) disable iff (reset)
      state_ff == kms_pkg::ST_EMIT |-> best_valid_ff)
      else $error("emit without a selected head");

   a_emit_drains_lane: assert property (@(posedge clock) disable iff (reset)
      state_ff == kms_pkg::ST_EMIT && out_free |=>
         rsp_valid_ff && !rsp_done_ff && !full_ff[$past(best_idx_ff)])
      else $error("emitted lane not emptied");

   a_done_clears: assert property (@(posedge clock) disable iff (reset)
      state_ff == kms_pkg::ST_DONE && out_free |=>
         full_ff == '0 && closed_ff == '0 && rsp_done_ff)
      else $error("done did not clear lanes");

   a_cmp_in_range: assert property (@(posedge clock) disable iff (reset)
      cmp_valid_ff |-> CW'(cmp_idx_ff) < n_act)
      else $error("compare beyond active lanes");
`endif

endmodule

@@ rtl/kway_merge_select.sv @@
`timescale 1ns / 1ps
// K-way merge of key-sorted streams.
// req_*: one item per accepted cycle (req_valid high, req_stall low). An item
//   fills the head of lane req_lane with key and value, or closes the lane
//   when req_stream_end is set. Items for lanes at or above lanes_used, for
//   closed lanes, or rows for a lane whose head is still full, change nothing.
// rsp_*: once every open lane in use holds a head, the smallest signed key
//   is sent (lowest lane on ties) and that lane waits for a refill. When no
//   lane in use is open, one result with rsp_done_res set and zero fields is
//   sent and all lanes return to empty and open.
// csr_*: writes lanes_used (always ready); write only while the block is idle.
// Flow: a two-entry input queue feeds a sequencer. Each item passes the idle
//   and evaluate states; one that ends the merge then sends the done result,
//   and one that gives a row runs the head scan, which reads one lane per
//   cycle from the head memory for n lanes, n being lanes_used held to
//   1..LANES, then emits the row. No new item is taken until the last is done.
// rsp_stall holds the result register; the queue keeps accepting until it
//   is full, then req_stall rises.
// Reset: lanes_used returns to 8, all lanes empty and open, queue empty.
module kway_merge_select #(
   parameter int LANES = 8
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [kms_pkg::LANE_W-1:0]       req_lane,
   input  logic signed [kms_pkg::KEY_W-1:0] req_entry_key,
   input  logic [kms_pkg::VAL_W-1:0]        req_entry_value,
   input  logic                             req_stream_end,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [kms_pkg::VAL_W-1:0]        rsp_out_value,
   output logic signed [kms_pkg::KEY_W-1:0] rsp_out_key,
   output logic [kms_pkg::LANE_W-1:0]       rsp_source_lane,
   output logic                             rsp_done_res,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [kms_pkg::CFG_W-1:0]        csr_lanes_used
);

   localparam int CW = $clog2(LANES + 1);

   logic [kms_pkg::CFG_W-1:0] lanes_used_ff, lanes_used_in;
   logic [CW-1:0]             n_act;
   logic                      q_valid;
   logic                      q_pop;
   kms_pkg::item_type         q_item;

   assign csr_ready = 1'b1;

   always_comb begin
      lanes_used_in = lanes_used_ff;
      if (csr_valid && csr_ready) begin
         lanes_used_in = csr_lanes_used;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lanes_used_ff <= kms_pkg::LANES_USED_RESET;
      end else begin
         lanes_used_ff <= lanes_used_in;
      end
   end

   // clamp to 1..LANES
   always_comb begin
      if (lanes_used_ff == '0) begin
         n_act = CW'(1);
      end else if (int'(lanes_used_ff) > LANES) begin
         n_act = CW'(LANES);
      end else begin
         n_act = CW'(lanes_used_ff);
      end
   end

   kms_front #(
      .LANES (LANES)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .n_act           (n_act),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_lane        (req_lane),
      .req_entry_key   (req_entry_key),
      .req_entry_value (req_entry_value),
      .req_stream_end  (req_stream_end),
      .q_valid         (q_valid),
      .q_item          (q_item),
      .q_pop           (q_pop)
   );

   kms_back #(
      .LANES (LANES)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .n_act           (n_act),
      .q_valid         (q_valid),
      .q_item          (q_item),
      .q_pop           (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_value   (rsp_out_value),
      .rsp_out_key     (rsp_out_key),
      .rsp_source_lane (rsp_source_lane),
      .rsp_done_res    (rsp_done_res)
   );

endmodule
